### rtl/assert_macros.svh
// assertion helpers, expect clk and arst_n in scope
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPLY(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("implication check failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("next-cycle check failed");

`endif

### rtl/hce_pkg.sv
package hce_pkg;

	localparam int NUM_REGS = 8;
	localparam int CFG_IDX_W = 4;
	localparam int CFG_SEL_W = 3;
	localparam int DEF_MAX_SUBDIVISIONS = 64;
	localparam int FRAC_BITS = 16;
	localparam int T_BITS = 16;
	localparam int T_ONE = 65536;

	localparam int ACC_W = 40;
	localparam int MB_W = 17;
	localparam int PROD_W = ACC_W + MB_W + 1;
	localparam int SQ_W = 65;
	localparam int ROOT_W = 33;
	localparam int DIVD_W = 47;
	localparam int DIVS_W = 33;
	localparam int QUO_W = 17;

	localparam logic [CFG_SEL_W-1:0] REG_START_X = 3'd0;
	localparam logic [CFG_SEL_W-1:0] REG_START_Y = 3'd1;
	localparam logic [CFG_SEL_W-1:0] REG_START_TX = 3'd2;
	localparam logic [CFG_SEL_W-1:0] REG_START_TY = 3'd3;
	localparam logic [CFG_SEL_W-1:0] REG_END_TX = 3'd4;
	localparam logic [CFG_SEL_W-1:0] REG_END_TY = 3'd5;
	localparam logic [CFG_SEL_W-1:0] REG_END_X = 3'd6;
	localparam logic [CFG_SEL_W-1:0] REG_END_Y = 3'd7;

	localparam logic signed [ACC_W-1:0] S32_MAX = ACC_W'(2147483647);
	localparam logic signed [ACC_W-1:0] S32_MIN = -S32_MAX - ACC_W'(1);

	typedef enum logic [1:0] {
		ACT_EVAL,
		ACT_LENGTH,
		ACT_AT_DIST,
		ACT_NONE
	} action_e;

	typedef struct packed {
		logic [1:0]  action;
		logic [16:0] param_t;
		logic [30:0] distance;
		logic [6:0]  subdivisions;
	} item_t;

	typedef struct packed {
		logic signed [31:0] pos_x;
		logic signed [31:0] pos_y;
		logic signed [31:0] slope_x;
		logic signed [31:0] slope_y;
		logic [30:0]        arc_length;
		logic               overflow;
	} result_t;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LATCH,
		OP_T_DIV,
		OP_T_LOAD,
		OP_H_INIT,
		OP_H_MUL,
		OP_H_ADD,
		OP_H_STORE,
		OP_ADVANCE,
		OP_SQ_MUL,
		OP_SQ_ACC,
		OP_SQRT,
		OP_SEG,
		OP_F_ZERO,
		OP_F_DIV,
		OP_F_LOAD,
		OP_IP_MUL,
		OP_IP_ADD,
		OP_FINISH
	} dp_op_e;

	typedef struct packed {
		dp_op_e     op;
		logic       axis;
		logic       tan;
		logic [1:0] step;
	} dp_cmd_t;

	typedef struct packed {
		action_e action;
		logic    div_busy;
		logic    sqrt_busy;
		logic    seg_first;
		logic    seg_last;
		logic    left_gt;
		logic    root_zero;
	} dp_stat_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_ROUTE,
		S_T_DIV,
		S_T_WAIT,
		S_T_LOAD,
		S_H_INIT,
		S_H_MUL,
		S_H_ADD,
		S_H_STORE,
		S_ADVANCE,
		S_SQ_MUL,
		S_SQ_ACC,
		S_SQRT,
		S_SQRT_WAIT,
		S_SEG,
		S_F_ZERO,
		S_F_DIV,
		S_F_WAIT,
		S_F_LOAD,
		S_IP_MUL,
		S_IP_ADD,
		S_FINISH,
		S_DONE
	} state_e;

	// {saturated, value}
	function automatic logic [32:0] sat32(input logic signed [ACC_W-1:0] v);
		logic [32:0] r;
		if (v > S32_MAX) begin
			r = {1'b1, 32'h7fff_ffff};
		end else if (v < S32_MIN) begin
			r = {1'b1, 32'h8000_0000};
		end else begin
			r = {1'b0, v[31:0]};
		end
		return r;
	endfunction

endpackage

### rtl/hce_sqrt.sv
module hce_sqrt import hce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [SQ_W-1:0]   radicand,
	output logic              busy,
	output logic [ROOT_W-1:0] root
);

	localparam int STEPS = ROOT_W;
	localparam int CW = $clog2(STEPS + 1);
	localparam int RW = ROOT_W + 2;

	logic [2*STEPS-1:0] val_q;
	logic [ROOT_W-1:0]  root_q;
	logic [RW-1:0]      rem_q;
	logic [CW-1:0]      cnt_q;
	logic               busy_q;
	logic [RW+1:0]      rem_sh;
	logic [RW+1:0]      trial;
	logic               ge;

	// one result bit per cycle, two radicand bits consumed
	assign rem_sh = {rem_q, val_q[2*STEPS-1 -: 2]};
	assign trial = (RW + 2)'({root_q, 2'b01});
	assign ge = rem_sh >= trial;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(STEPS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			val_q <= (2 * STEPS)'(radicand);
			root_q <= '0;
			rem_q <= '0;
		end else if (busy_q) begin
			val_q <= {val_q[2*STEPS-3:0], 2'b00};
			root_q <= {root_q[ROOT_W-2:0], ge};
			rem_q <= ge ? RW'(rem_sh - trial) : RW'(rem_sh);
		end
	end

	assign busy = busy_q;
	assign root = root_q;

endmodule

### rtl/hce_div.sv
`include "assert_macros.svh"

module hce_div import hce_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              start,
	input  logic [DIVD_W-1:0] dividend,
	input  logic [DIVS_W-1:0] divisor,
	output logic              busy,
	output logic [QUO_W-1:0]  quotient
);

	localparam int CW = $clog2(QUO_W + 1);

	logic [DIVS_W-1:0] rem_q;
	logic [DIVS_W-1:0] div_q;
	logic [QUO_W-1:0]  low_q;
	logic [QUO_W-1:0]  quo_q;
	logic [CW-1:0]     cnt_q;
	logic              busy_q;
	logic [DIVS_W:0]   rem_sh;
	logic              ge;

	// restoring division, quotient known to fit QUO_W bits
	assign rem_sh = {rem_q, low_q[QUO_W-1]};
	assign ge = rem_sh >= {1'b0, div_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q <= CW'(QUO_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - CW'(1);
			if (cnt_q == CW'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= DIVS_W'(dividend[DIVD_W-1:QUO_W]);
			low_q <= dividend[QUO_W-1:0];
			div_q <= divisor;
			quo_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? DIVS_W'(rem_sh - {1'b0, div_q}) : rem_sh[DIVS_W-1:0];
			low_q <= {low_q[QUO_W-2:0], 1'b0};
			quo_q <= {quo_q[QUO_W-2:0], ge};
		end
	end

	assign busy = busy_q;
	assign quotient = quo_q;

	`ASSERT_IMPLY(a_quo_range, $fell(busy_q), quo_q <= QUO_W'(T_ONE))
	`ASSERT_NEXT(a_div_runs, start, busy_q && cnt_q == CW'(QUO_W))
	`ASSERT_IMPLY(a_div_count, busy_q, cnt_q != '0)

endmodule

### rtl/hce_datapath.sv
module hce_datapath import hce_pkg::*; #(
	parameter int MAX_SUBDIVISIONS = DEF_MAX_SUBDIVISIONS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	input  item_t                item,
	input  dp_cmd_t              cmd,
	output dp_stat_t             stat,
	output result_t              result
);

	localparam int NW = $clog2(MAX_SUBDIVISIONS + 1);
	localparam int ALEN_W = ROOT_W + NW;
	localparam logic signed [PROD_W-1:0] HALF_T = PROD_W'(1) <<< (T_BITS - 1);
	localparam logic signed [PROD_W-1:0] HALF_F = PROD_W'(1) <<< (FRAC_BITS - 1);

	logic [31:0]               cfg_q [NUM_REGS];
	action_e                   action_q;
	logic [NW-1:0]             n_q;
	logic [NW-1:0]             seg_q;
	logic [MB_W-1:0]           tc_q;
	logic [MB_W-1:0]           f_q;
	logic [30:0]               left_q;
	logic [ROOT_W-1:0]         len_q;
	logic signed [ACC_W-1:0]   coef_a_q [2];
	logic signed [ACC_W-1:0]   coef_b_q [2];
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic [SQ_W-1:0]           sum_q;
	logic signed [31:0]        pos_q [2];
	logic signed [31:0]        slope_q [2];
	logic signed [31:0]        cur_q [2];
	logic signed [31:0]        prev_q [2];
	logic [ALEN_W-1:0]         alen_q;
	logic                      ovf_q;
	result_t                   res_q;

	logic [NW-1:0]             n_in;
	logic signed [ACC_W-1:0]   coef_a_in [2];
	logic signed [ACC_W-1:0]   coef_b_in [2];
	logic signed [ACC_W-1:0]   c_ext;
	logic signed [ACC_W-1:0]   d_ext;
	logic signed [ACC_W-1:0]   addend;
	logic signed [ACC_W-1:0]   mul_a;
	logic [MB_W-1:0]           mul_b;
	logic signed [PROD_W-1:0]  rnd_t;
	logic signed [PROD_W-1:0]  rnd_f;
	logic signed [ACC_W-1:0]   shr_t;
	logic signed [ACC_W-1:0]   shr_f;
	logic                      diff_ax;
	logic signed [32:0]        diff;
	logic [31:0]               mag;
	logic [32:0]               sat_st;
	logic [32:0]               sat_ip;
	logic                      div_start;
	logic [DIVD_W-1:0]         div_dividend;
	logic [DIVS_W-1:0]         div_divisor;
	logic                      div_busy;
	logic [QUO_W-1:0]          div_quo;
	logic                      sqrt_busy;
	logic [ROOT_W-1:0]         root;
	logic                      left_gt;
	logic                      alen_big;

	always_comb begin
		if (item.subdivisions == '0) begin
			n_in = NW'(1);
		end else if (32'(item.subdivisions) > 32'(MAX_SUBDIVISIONS)) begin
			n_in = NW'(MAX_SUBDIVISIONS);
		end else begin
			n_in = NW'(item.subdivisions);
		end
	end

	// power basis: a = 2p0+t0+t1-2p1, b = 3p1-3p0-2t0-t1
	always_comb begin
		for (int ax = 0; ax < 2; ax++) begin
			coef_a_in[ax] = (ACC_W'($signed(cfg_q[REG_START_X + CFG_SEL_W'(ax)])) <<< 1)
				+ ACC_W'($signed(cfg_q[REG_START_TX + CFG_SEL_W'(ax)]))
				+ ACC_W'($signed(cfg_q[REG_END_TX + CFG_SEL_W'(ax)]))
				- (ACC_W'($signed(cfg_q[REG_END_X + CFG_SEL_W'(ax)])) <<< 1);
			coef_b_in[ax] = ACC_W'(3) * ACC_W'($signed(cfg_q[REG_END_X + CFG_SEL_W'(ax)]))
				- ACC_W'(3) * ACC_W'($signed(cfg_q[REG_START_X + CFG_SEL_W'(ax)]))
				- (ACC_W'($signed(cfg_q[REG_START_TX + CFG_SEL_W'(ax)])) <<< 1)
				- ACC_W'($signed(cfg_q[REG_END_TX + CFG_SEL_W'(ax)]));
		end
	end

	assign c_ext = cmd.axis ? ACC_W'($signed(cfg_q[REG_START_TY]))
		: ACC_W'($signed(cfg_q[REG_START_TX]));
	assign d_ext = cmd.axis ? ACC_W'($signed(cfg_q[REG_START_Y]))
		: ACC_W'($signed(cfg_q[REG_START_X]));

	always_comb begin
		if (cmd.tan) begin
			addend = (cmd.step == 2'd0) ? (coef_b_q[cmd.axis] <<< 1) : c_ext;
		end else begin
			case (cmd.step)
				2'd0: addend = coef_b_q[cmd.axis];
				2'd1: addend = c_ext;
				default: addend = d_ext;
			endcase
		end
	end

	// squaring steps 0-1 take dx, steps 2-3 take dy
	assign diff_ax = (cmd.op == OP_SQ_MUL) ? cmd.step[1] : cmd.axis;
	assign diff = 33'($signed(cur_q[diff_ax])) - 33'($signed(prev_q[diff_ax]));
	assign mag = diff[32] ? 32'(-diff) : diff[31:0];

	// shared multiplier operands
	always_comb begin
		case (cmd.op)
			OP_SQ_MUL: begin
				mul_a = ACC_W'({1'b0, mag});
				mul_b = cmd.step[0] ? {1'b0, mag[15:0]} : {1'b0, mag[31:16]};
			end
			OP_IP_MUL: begin
				mul_a = ACC_W'(diff);
				mul_b = f_q;
			end
			default: begin
				mul_a = acc_q;
				mul_b = tc_q;
			end
		endcase
	end

	assign rnd_t = prod_q + HALF_T;
	assign rnd_f = prod_q + HALF_F;
	assign shr_t = ACC_W'(rnd_t >>> T_BITS);
	assign shr_f = ACC_W'(rnd_f >>> FRAC_BITS);
	assign sat_st = sat32(acc_q);
	assign sat_ip = sat32(ACC_W'($signed(prev_q[cmd.axis])) + shr_f);
	assign left_gt = {2'b00, left_q} > root;
	assign alen_big = |alen_q[ALEN_W-1:31];

	assign div_start = (cmd.op == OP_T_DIV) || (cmd.op == OP_F_DIV);
	assign div_dividend = (cmd.op == OP_F_DIV) ? (DIVD_W'(left_q) << FRAC_BITS)
		: (DIVD_W'(seg_q) << T_BITS);
	assign div_divisor = (cmd.op == OP_F_DIV) ? len_q : DIVS_W'(n_q);

	hce_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (div_dividend),
		.divisor  (div_divisor),
		.busy     (div_busy),
		.quotient (div_quo)
	);

	hce_sqrt u_sqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (cmd.op == OP_SQRT),
		.radicand (sum_q),
		.busy     (sqrt_busy),
		.root     (root)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_REGS; i++) begin
				cfg_q[i] <= '0;
			end
		end else if (cfg_we && cfg_index < CFG_IDX_W'(NUM_REGS)) begin
			cfg_q[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			action_q <= ACT_EVAL;
			seg_q <= '0;
			ovf_q <= 1'b0;
		end else begin
			case (cmd.op)
				OP_LATCH: begin
					action_q <= action_e'(item.action);
					seg_q <= '0;
					ovf_q <= 1'b0;
				end
				OP_H_STORE: ovf_q <= ovf_q | sat_st[32];
				OP_IP_ADD: ovf_q <= ovf_q | sat_ip[32];
				OP_ADVANCE: seg_q <= seg_q + NW'(1);
				OP_SEG: begin
					if (action_q == ACT_LENGTH || left_gt) begin
						seg_q <= seg_q + NW'(1);
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		case (cmd.op)
			OP_LATCH: begin
				n_q <= n_in;
				tc_q <= (item.param_t > MB_W'(T_ONE)) ? MB_W'(T_ONE) : item.param_t;
				left_q <= item.distance;
				alen_q <= '0;
				for (int ax = 0; ax < 2; ax++) begin
					coef_a_q[ax] <= coef_a_in[ax];
					coef_b_q[ax] <= coef_b_in[ax];
					pos_q[ax] <= '0;
					slope_q[ax] <= '0;
				end
			end
			OP_T_LOAD: tc_q <= div_quo;
			OP_H_INIT: begin
				acc_q <= cmd.tan ? ((coef_a_q[cmd.axis] <<< 1) + coef_a_q[cmd.axis])
					: coef_a_q[cmd.axis];
			end
			OP_H_MUL, OP_SQ_MUL, OP_IP_MUL: begin
				prod_q <= PROD_W'(mul_a) * PROD_W'($signed({1'b0, mul_b}));
			end
			OP_H_ADD: acc_q <= shr_t + addend;
			OP_H_STORE: begin
				if (action_q == ACT_EVAL) begin
					if (cmd.tan) begin
						slope_q[cmd.axis] <= sat_st[31:0];
					end else begin
						pos_q[cmd.axis] <= sat_st[31:0];
					end
				end else begin
					cur_q[cmd.axis] <= sat_st[31:0];
				end
			end
			OP_ADVANCE: prev_q <= cur_q;
			OP_SQ_ACC: begin
				if (cmd.step == 2'd0) begin
					sum_q <= SQ_W'(prod_q[47:0]) << 16;
				end else if (!cmd.step[0]) begin
					sum_q <= sum_q + (SQ_W'(prod_q[47:0]) << 16);
				end else begin
					sum_q <= sum_q + SQ_W'(prod_q[47:0]);
				end
			end
			OP_SEG: begin
				len_q <= root;
				if (action_q == ACT_LENGTH) begin
					alen_q <= alen_q + ALEN_W'(root);
					prev_q <= cur_q;
				end else if (left_gt) begin
					left_q <= left_q - 31'(root);
					prev_q <= cur_q;
				end
			end
			OP_F_ZERO: f_q <= '0;
			OP_F_LOAD: f_q <= div_quo;
			OP_IP_ADD: pos_q[cmd.axis] <= sat_ip[31:0];
			OP_FINISH: begin
				res_q.pos_x <= pos_q[0];
				res_q.pos_y <= pos_q[1];
				res_q.slope_x <= slope_q[0];
				res_q.slope_y <= slope_q[1];
				res_q.arc_length <= alen_big ? 31'h7fff_ffff : alen_q[30:0];
				res_q.overflow <= ovf_q | alen_big;
			end
			default: ;
		endcase
	end

	assign stat.action = action_q;
	assign stat.div_busy = div_busy;
	assign stat.sqrt_busy = sqrt_busy;
	assign stat.seg_first = seg_q == '0;
	assign stat.seg_last = seg_q == n_q;
	assign stat.left_gt = left_gt;
	assign stat.root_zero = root == '0;
	assign result = res_q;

endmodule

### rtl/hce_ctrl.sv
`include "assert_macros.svh"

module hce_ctrl import hce_pkg::*; (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	input  dp_stat_t stat,
	output dp_cmd_t  cmd,
	output logic     busy,
	output logic     done
);

	state_e     state_q;
	state_e     state_d;
	logic       axis_q;
	logic       tan_q;
	logic [1:0] step_q;
	logic       h_last;

	assign h_last = tan_q ? (step_q == 2'd1) : (step_q == 2'd2);

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: if (start) state_d = S_ROUTE;
			S_ROUTE: begin
				unique case (stat.action)
					ACT_EVAL: state_d = S_H_INIT;
					ACT_LENGTH, ACT_AT_DIST: state_d = S_T_DIV;
					default: state_d = S_FINISH;
				endcase
			end
			S_T_DIV: state_d = S_T_WAIT;
			S_T_WAIT: if (!stat.div_busy) state_d = S_T_LOAD;
			S_T_LOAD: state_d = S_H_INIT;
			S_H_INIT: state_d = S_H_MUL;
			S_H_MUL: state_d = S_H_ADD;
			S_H_ADD: state_d = h_last ? S_H_STORE : S_H_MUL;
			S_H_STORE: begin
				if (stat.action == ACT_EVAL) begin
					state_d = (tan_q && axis_q) ? S_FINISH : S_H_INIT;
				end else if (!axis_q) begin
					state_d = S_H_INIT;
				end else begin
					state_d = stat.seg_first ? S_ADVANCE : S_SQ_MUL;
				end
			end
			S_ADVANCE: state_d = S_T_DIV;
			S_SQ_MUL: state_d = S_SQ_ACC;
			S_SQ_ACC: state_d = (step_q == 2'd3) ? S_SQRT : S_SQ_MUL;
			S_SQRT: state_d = S_SQRT_WAIT;
			S_SQRT_WAIT: if (!stat.sqrt_busy) state_d = S_SEG;
			S_SEG: begin
				if (stat.action == ACT_LENGTH) begin
					state_d = stat.seg_last ? S_FINISH : S_T_DIV;
				end else if (stat.left_gt) begin
					state_d = stat.seg_last ? S_F_ZERO : S_T_DIV;
				end else begin
					state_d = stat.root_zero ? S_F_ZERO : S_F_DIV;
				end
			end
			S_F_ZERO: state_d = S_IP_MUL;
			S_F_DIV: state_d = S_F_WAIT;
			S_F_WAIT: if (!stat.div_busy) state_d = S_F_LOAD;
			S_F_LOAD: state_d = S_IP_MUL;
			S_IP_MUL: state_d = S_IP_ADD;
			S_IP_ADD: state_d = axis_q ? S_FINISH : S_IP_MUL;
			S_FINISH: state_d = S_DONE;
			S_DONE: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_comb begin
		cmd.axis = axis_q;
		cmd.tan = tan_q;
		cmd.step = step_q;
		unique case (state_q)
			S_IDLE: cmd.op = start ? OP_LATCH : OP_NONE;
			S_T_DIV: cmd.op = OP_T_DIV;
			S_T_LOAD: cmd.op = OP_T_LOAD;
			S_H_INIT: cmd.op = OP_H_INIT;
			S_H_MUL: cmd.op = OP_H_MUL;
			S_H_ADD: cmd.op = OP_H_ADD;
			S_H_STORE: cmd.op = OP_H_STORE;
			S_ADVANCE: cmd.op = OP_ADVANCE;
			S_SQ_MUL: cmd.op = OP_SQ_MUL;
			S_SQ_ACC: cmd.op = OP_SQ_ACC;
			S_SQRT: cmd.op = OP_SQRT;
			S_SEG: cmd.op = OP_SEG;
			S_F_ZERO: cmd.op = OP_F_ZERO;
			S_F_DIV: cmd.op = OP_F_DIV;
			S_F_LOAD: cmd.op = OP_F_LOAD;
			S_IP_MUL: cmd.op = OP_IP_MUL;
			S_IP_ADD: cmd.op = OP_IP_ADD;
			S_FINISH: cmd.op = OP_FINISH;
			default: cmd.op = OP_NONE;
		endcase
		busy = state_q != S_IDLE;
		done = state_q == S_DONE;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			axis_q <= 1'b0;
			tan_q <= 1'b0;
			step_q <= '0;
		end else begin
			state_q <= state_d;
			case (state_q)
				S_ROUTE, S_T_LOAD: begin
					axis_q <= 1'b0;
					tan_q <= 1'b0;
				end
				S_H_INIT: step_q <= '0;
				S_H_ADD, S_SQ_ACC: step_q <= step_q + 2'd1;
				S_H_STORE: begin
					// x then y, position then tangent
					if (axis_q) begin
						tan_q <= !tan_q;
					end
					axis_q <= !axis_q;
					step_q <= '0;
				end
				S_IP_ADD: axis_q <= !axis_q;
				default: ;
			endcase
		end
	end

	`ASSERT_NEXT(a_done_pulse, done, !done)
	`ASSERT_NEXT(a_done_frees, done, !busy)
	`ASSERT_NEXT(a_accept_busy, start && !busy, busy && state_q == S_ROUTE)
	`ASSERT_IMPLY(a_walk_action, state_q == S_SQRT_WAIT, stat.action == ACT_LENGTH || stat.action == ACT_AT_DIST)

endmodule

### rtl/hermite_curve_evaluator_unit.sv
// 2D cubic hermite curve unit, Q16.16 points and tangents in eight config registers.
// one item at a time. length and point-at-distance walk N segments plus the start point,
// paced by the bit-serial 17-step divider that places each segment point and the 33-step
// square root of each chord, plus a final fraction divide for point-at-distance. done
// pulses for one cycle with the result, which the receiver must take then; busy stays
// high until after.
module hermite_curve_evaluator_unit import hce_pkg::*; #(
	parameter int MAX_SUBDIVISIONS = DEF_MAX_SUBDIVISIONS
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	output logic                 busy,
	input  item_t                item,
	output logic                 done,
	output result_t              result,
	input  logic                 cfg_valid,
	output logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data
);

	dp_cmd_t  cmd;
	dp_stat_t stat;

	assign cfg_ready = 1'b1;

	hce_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.stat   (stat),
		.cmd    (cmd),
		.busy   (busy),
		.done   (done)
	);

	hce_datapath #(
		.MAX_SUBDIVISIONS (MAX_SUBDIVISIONS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_valid && cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.item      (item),
		.cmd       (cmd),
		.stat      (stat),
		.result    (result)
	);

endmodule

### dv/hce_checker.sv
module hce_checker import hce_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 start,
	input  logic                 busy,
	input  item_t                item,
	input  logic                 done,
	input  result_t              result,
	input  logic                 cfg_valid,
	input  logic                 cfg_ready,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [31:0]          cfg_data,
	output int                   fails,
	output int                   pending
);
	timeunit 1ns;
	timeprecision 1ps;

	logic signed [31:0] curve [NUM_REGS];
	result_t            expected_q [$];

	function automatic longint round16(longint v);
		return (v + 64'sd32768) >>> T_BITS;
	endfunction

	function automatic longint clip32(longint v, inout bit ovf);
		if (v > 64'sd2147483647) begin
			ovf = 1'b1;
			return 64'sd2147483647;
		end
		if (v < -64'sd2147483648) begin
			ovf = 1'b1;
			return -64'sd2147483648;
		end
		return v;
	endfunction

	// power-basis coefficients a, b, c, d for one axis
	function automatic void poly(bit axis, output longint a, output longint b,
			output longint c, output longint d);
		longint p0, t0, t1, p1;
		p0 = curve[REG_START_X + axis];
		t0 = curve[REG_START_TX + axis];
		t1 = curve[REG_END_TX + axis];
		p1 = curve[REG_END_X + axis];
		a = 2 * p0 + t0 + t1 - 2 * p1;
		b = 3 * p1 - 3 * p0 - 2 * t0 - t1;
		c = t0;
		d = p0;
	endfunction

	function automatic longint curve_pos(bit axis, longint t);
		longint a, b, c, d, v;
		poly(axis, a, b, c, d);
		v = round16(a * t) + b;
		v = round16(v * t) + c;
		return round16(v * t) + d;
	endfunction

	function automatic longint curve_slope(bit axis, longint t);
		longint a, b, c, d, v;
		poly(axis, a, b, c, d);
		v = round16(3 * a * t) + 2 * b;
		return round16(v * t) + c;
	endfunction

	function automatic longint chord_len(longint dx, longint dy);
		logic [65:0] ax, ay, sq, cand;
		logic [32:0] root;
		ax = dx < 0 ? -dx : dx;
		ay = dy < 0 ? -dy : dy;
		sq = ax * ax + ay * ay;
		root = '0;
		for (int k = 32; k >= 0; k--) begin
			cand = root | (33'd1 << k);
			if (cand * cand <= sq) begin
				root = cand[32:0];
			end
		end
		return longint'(root);
	endfunction

	function automatic void knot(int i, int n, output longint x, output longint y,
			inout bit ovf);
		longint t;
		t = (longint'(i) << T_BITS) / n;
		x = clip32(curve_pos(1'b0, t), ovf);
		y = clip32(curve_pos(1'b1, t), ovf);
	endfunction

	function automatic result_t predict(item_t it);
		result_t r;
		longint  t, px, py, ax, ay, bx, by, seg, total, rest, frac;
		int      n;
		bit      ovf;
		r = '0;
		ovf = 1'b0;
		t = it.param_t > T_ONE ? T_ONE : it.param_t;
		n = it.subdivisions == 0 ? 1 : int'(it.subdivisions);
		if (n > DEF_MAX_SUBDIVISIONS) begin
			n = DEF_MAX_SUBDIVISIONS;
		end
		case (action_e'(it.action))
			ACT_EVAL: begin
				r.pos_x = clip32(curve_pos(1'b0, t), ovf);
				r.pos_y = clip32(curve_pos(1'b1, t), ovf);
				r.slope_x = clip32(curve_slope(1'b0, t), ovf);
				r.slope_y = clip32(curve_slope(1'b1, t), ovf);
			end
			ACT_LENGTH: begin
				total = 0;
				knot(0, n, ax, ay, ovf);
				for (int i = 1; i <= n; i++) begin
					knot(i, n, bx, by, ovf);
					total += chord_len(bx - ax, by - ay);
					ax = bx;
					ay = by;
				end
				if (total > 64'sh7fff_ffff) begin
					total = 64'sh7fff_ffff;
					ovf = 1'b1;
				end
				r.arc_length = total[30:0];
			end
			ACT_AT_DIST: begin
				rest = it.distance;
				seg = 0;
				frac = 0;
				bx = 0;
				by = 0;
				knot(0, n, ax, ay, ovf);
				for (int i = 1; i <= n; i++) begin
					knot(i, n, bx, by, ovf);
					seg = chord_len(bx - ax, by - ay);
					if (rest > seg) begin
						rest -= seg;
					end else begin
						break;
					end
					ax = bx;
					ay = by;
				end
				// zero-length segment keeps fraction zero
				if (seg != 0) begin
					frac = (rest << FRAC_BITS) / seg;
				end
				if (frac > (64'sd1 << FRAC_BITS)) begin
					frac = 64'sd1 << FRAC_BITS;
				end
				px = ax + round16((bx - ax) * frac);
				py = ay + round16((by - ay) * frac);
				r.pos_x = clip32(px, ovf);
				r.pos_y = clip32(py, ovf);
			end
			default: begin
			end
		endcase
		r.overflow = ovf;
		return r;
	endfunction

	function automatic int diff(string name, longint exp_v, longint act_v);
		if (exp_v != act_v) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_v, act_v);
			return 1;
		end
		return 0;
	endfunction

	assign pending = expected_q.size();

	always_ff @(posedge clk or negedge arst_n) begin
		result_t exp_r;
		int      bad;
		if (!arst_n) begin
			fails <= 0;
			for (int i = 0; i < NUM_REGS; i++) begin
				curve[i] <= '0;
			end
			expected_q.delete();
		end else begin
			bad = 0;
			if (done) begin
				if (expected_q.size() == 0) begin
					$error("result with no item outstanding");
					bad++;
				end else begin
					exp_r = expected_q.pop_front();
					bad += diff("pos_x", exp_r.pos_x, result.pos_x);
					bad += diff("pos_y", exp_r.pos_y, result.pos_y);
					bad += diff("slope_x", exp_r.slope_x, result.slope_x);
					bad += diff("slope_y", exp_r.slope_y, result.slope_y);
					bad += diff("arc_length", exp_r.arc_length, result.arc_length);
					bad += diff("overflow", exp_r.overflow, result.overflow);
				end
			end
			if (start && !busy) begin
				expected_q.push_back(predict(item));
			end
			if (cfg_valid && cfg_ready && cfg_index < NUM_REGS) begin
				curve[cfg_index[CFG_SEL_W-1:0]] <= cfg_data;
			end
			if (bad != 0) begin
				fails <= fails + 1;
			end
		end
	end

endmodule

### dv/tb.sv
module tb import hce_pkg::*;;
	timeunit 1ns;
	timeprecision 1ps;

	localparam longint CYCLE_LIMIT = 40_000_000;

	logic                 clk;
	logic                 arst_n;
	logic                 start;
	logic                 busy;
	item_t                item;
	logic                 done;
	result_t              result;
	logic                 cfg_valid;
	logic                 cfg_ready;
	logic [CFG_IDX_W-1:0] cfg_index;
	logic [31:0]          cfg_data;
	int                   fails;
	int                   pending;
	longint               cycles;
	int unsigned          dist_span;

	hermite_curve_evaluator_unit u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	hce_checker u_checker (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (start),
		.busy      (busy),
		.item      (item),
		.done      (done),
		.result    (result),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.fails     (fails),
		.pending   (pending)
	);

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// start stays high across back-to-back items
	task automatic push_item(item_t it, bit may_gap);
		start <= 1'b1;
		item <= it;
		do begin
			@(posedge clk);
		end while (busy);
		if (may_gap && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic write_reg(logic [CFG_SEL_W-1:0] sel, logic [31:0] v);
		cfg_valid <= 1'b1;
		cfg_index <= CFG_IDX_W'(sel);
		cfg_data <= v;
		do begin
			@(posedge clk);
		end while (!cfg_ready);
		cfg_valid <= 1'b0;
		if ($urandom_range(0, 2) == 0) begin
			repeat ($urandom_range(1, 12)) @(posedge clk);
		end
	endtask

	task automatic drain();
		start <= 1'b0;
		@(posedge clk);
		while (pending != 0) begin
			@(posedge clk);
		end
	endtask

	task automatic load_curve(logic [31:0] x0, logic [31:0] y0, logic [31:0] tx0,
			logic [31:0] ty0, logic [31:0] tx1, logic [31:0] ty1, logic [31:0] x1,
			logic [31:0] y1);
		drain();
		write_reg(REG_START_X, x0);
		write_reg(REG_START_Y, y0);
		write_reg(REG_START_TX, tx0);
		write_reg(REG_START_TY, ty0);
		write_reg(REG_END_TX, tx1);
		write_reg(REG_END_TY, ty1);
		write_reg(REG_END_X, x1);
		write_reg(REG_END_Y, y1);
	endtask

	function automatic logic [31:0] coord(int kind);
		int unsigned span;
		int unsigned pick;
		case (kind)
			0: span = 32'h0010_0000;
			1: span = 32'h0100_0000;
			2: return $urandom;
			default: begin
				pick = $urandom_range(0, 3);
				return pick == 0 ? 32'h7fff_ffff : pick == 1 ? 32'h8000_0000 :
					pick == 2 ? 32'h0 : $urandom;
			end
		endcase
		return 32'($urandom_range(0, 2 * span)) - span;
	endfunction

	function automatic item_t make_item(action_e act, int unsigned t, int unsigned d,
			int unsigned n);
		item_t it;
		it.action = act;
		it.param_t = 17'(t);
		it.distance = 31'(d);
		it.subdivisions = 7'(n);
		return it;
	endfunction

	function automatic item_t random_item();
		int unsigned roll;
		int unsigned n;
		int unsigned d;
		int unsigned t;
		action_e     act;
		roll = $urandom_range(0, 99);
		act = roll < 30 ? ACT_EVAL : roll < 55 ? ACT_LENGTH : roll < 92 ? ACT_AT_DIST : ACT_NONE;
		roll = $urandom_range(0, 99);
		// long segment walks stay rare
		n = roll < 80 ? $urandom_range(1, 8) : roll < 92 ? $urandom_range(9, 20) :
			roll < 95 ? 0 : roll < 98 ? $urandom_range(21, 64) : $urandom_range(65, 127);
		roll = $urandom_range(0, 99);
		d = roll < 60 ? $urandom_range(0, dist_span) : roll < 75 ? 0 : $urandom;
		t = $urandom_range(0, 9) == 0 ? $urandom_range(65537, 131071) :
			$urandom_range(0, 9) == 0 ? ($urandom_range(0, 1) ? 0 : T_ONE) :
			$urandom_range(0, T_ONE);
		return make_item(act, t, d, n);
	endfunction

	initial begin
		int kind;
		cycles = 0;
		arst_n = 1'b0;
		start = 1'b0;
		item = '0;
		cfg_valid = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		dist_span = 32'h0040_0000;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset curve is a single point, so every segment has zero length
		push_item(make_item(ACT_LENGTH, 0, 0, 4), 1'b0);
		push_item(make_item(ACT_AT_DIST, 0, 32'h0001_0000, 4), 1'b0);
		push_item(make_item(ACT_EVAL, 32768, 0, 1), 1'b0);

		load_curve(32'hfffe_0000, 32'h0001_8000, 32'h0004_0000, 32'h0002_0000,
			32'hfffd_0000, 32'h0005_0000, 32'h0003_0000, 32'hffff_0000);
		push_item(make_item(ACT_EVAL, 0, 0, 1), 1'b0);
		push_item(make_item(ACT_EVAL, T_ONE, 0, 1), 1'b0);
		push_item(make_item(ACT_EVAL, 131071, 0, 1), 1'b0);
		push_item(make_item(ACT_EVAL, 12345, 0, 1), 1'b0);
		push_item(make_item(ACT_LENGTH, 0, 0, 0), 1'b0);
		push_item(make_item(ACT_LENGTH, 0, 0, 1), 1'b0);
		push_item(make_item(ACT_LENGTH, 0, 0, 64), 1'b0);
		push_item(make_item(ACT_LENGTH, 0, 0, 127), 1'b0);
		push_item(make_item(ACT_AT_DIST, 0, 0, 3), 1'b0);
		push_item(make_item(ACT_AT_DIST, 0, 32'h0002_8000, 3), 1'b0);
		push_item(make_item(ACT_AT_DIST, 0, 32'h7fff_ffff, 3), 1'b0);
		push_item(make_item(ACT_NONE, 131071, 32'h7fff_ffff, 127), 1'b0);

		load_curve(32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 32'h8000_0000,
			32'h7fff_ffff, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff);
		push_item(make_item(ACT_EVAL, 32768, 0, 1), 1'b0);
		push_item(make_item(ACT_LENGTH, 0, 0, 8), 1'b0);
		push_item(make_item(ACT_AT_DIST, 0, 32'h7fff_ffff, 8), 1'b0);
		push_item(make_item(ACT_AT_DIST, 0, 32'h1234_5678, 8), 1'b0);

		for (int phase = 0; phase < 8; phase++) begin
			kind = phase % 4;
			load_curve(coord(kind), coord(kind), coord(kind), coord(kind),
				coord(kind), coord(kind), coord(kind), coord(kind));
			dist_span = kind == 0 ? 32'h0040_0000 : kind == 1 ? 32'h0400_0000 : 32'h7fff_ffff;
			for (int k = 0; k < 160; k++) begin
				push_item(random_item(), phase < 7);
			end
		end

		drain();
		repeat (50) @(posedge clk);
		if (fails == 0) begin
			$display("Regression PASS");
		end else begin
			$display("Regression FAIL");
		end
		$finish;
	end

endmodule
